// ----- rtl/core/cvp_pkg.sv -----
// shared types, constants and saturating add for the chebyshev to power converter
package cvp_pkg;

  localparam int CFG_W   = 5;
  localparam int COEF_W  = 32;
  localparam int BASIS_W = 30;
  localparam int PROD_W  = COEF_W + BASIS_W;
  localparam int POWER_W = 64;

  localparam logic [CFG_W-1:0] TERM_COUNT_RESET = 5'd16;

  typedef enum logic [4:0] {
    S_INIT = 5'b00001,
    S_LOAD = 5'b00010,
    S_RD   = 5'b00100,
    S_MUL  = 5'b01000,
    S_ACC  = 5'b10000
  } state_e;

  // add one product to the accumulator, clamp to the signed 64-bit range
  function automatic logic signed [POWER_W-1:0] sat_add(
    input logic signed [POWER_W-1:0] a,
    input logic signed [PROD_W-1:0]  b
  );
    logic signed [POWER_W:0] s;
    logic signed [POWER_W-1:0] r;
    s = {a[POWER_W-1], a} + {{(POWER_W+1-PROD_W){b[PROD_W-1]}}, b};
    if (s[POWER_W] != s[POWER_W-1]) begin
      r = s[POWER_W] ? {1'b1, {(POWER_W-1){1'b0}}} : {1'b0, {(POWER_W-1){1'b1}}};
    end else begin
      r = s[POWER_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/cvp_ram.sv -----
// generic single write port ram with registered read
module cvp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/cvp_basis_gen.sv -----
// builds the chebyshev basis matrix column by column with two shift lines
module cvp_basis_gen #(
  parameter int MAX_TERMS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 run_i,
  output logic                                 we_o,
  output logic [((MAX_TERMS*MAX_TERMS > 1) ? $clog2(MAX_TERMS*MAX_TERMS) : 1)-1:0] addr_o,
  output logic signed [cvp_pkg::BASIS_W-1:0]   data_o,
  output logic                                 done_o
);

  localparam int DEPTH = MAX_TERMS * MAX_TERMS;
  localparam int BAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int JW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam logic [BAW-1:0] LAST_ADDR = BAW'(DEPTH - 1);
  localparam logic [JW-1:0]  LAST_J    = JW'(MAX_TERMS - 1);

  logic [BAW-1:0] addr_q, addr_d;
  logic [JW-1:0]  j_q, j_d;
  logic [JW-1:0]  i_q, i_d;
  logic signed [cvp_pkg::BASIS_W-1:0] line1_q [MAX_TERMS];
  logic signed [cvp_pkg::BASIS_W-1:0] line2_q [MAX_TERMS];
  logic signed [cvp_pkg::BASIS_W-1:0] last1_q;
  logic signed [cvp_pkg::BASIS_W:0]   twice;
  logic signed [cvp_pkg::BASIS_W:0]   diff;
  logic signed [cvp_pkg::BASIS_W-1:0] val;

  // line1 holds column i-1, line2 column i-2, heads at index 0
  always_comb begin
    twice = (j_q == '0) ? '0 : {last1_q, 1'b0};
    diff  = twice - {line2_q[0][cvp_pkg::BASIS_W-1], line2_q[0]};
    if (i_q == '0) begin
      val = (j_q == '0) ? cvp_pkg::BASIS_W'(1) : '0;
    end else if (i_q == JW'(1)) begin
      val = (j_q == JW'(1)) ? cvp_pkg::BASIS_W'(1) : '0;
    end else begin
      val = diff[cvp_pkg::BASIS_W-1:0];
    end
  end

  always_comb begin
    addr_d = addr_q;
    j_d    = j_q;
    i_d    = i_q;
    if (run_i) begin
      addr_d = addr_q + BAW'(1);
      if (j_q == LAST_J) begin
        j_d = '0;
        i_d = i_q + JW'(1);
      end else begin
        j_d = j_q + JW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      j_q    <= '0;
      i_q    <= '0;
    end else begin
      addr_q <= addr_d;
      j_q    <= j_d;
      i_q    <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_i) begin
      for (int m = 0; m < MAX_TERMS - 1; m++) begin
        line1_q[m] <= line1_q[m+1];
        line2_q[m] <= line2_q[m+1];
      end
      line1_q[MAX_TERMS-1] <= val;
      line2_q[MAX_TERMS-1] <= line1_q[0];
      last1_q              <= line1_q[0];
    end
  end

  assign we_o   = run_i;
  assign addr_o = addr_q;
  assign data_o = val;
  assign done_o = run_i && (addr_q == LAST_ADDR);

endmodule

// ----- rtl/core/chebyshev_to_power_convert.sv -----
// chebyshev series to power series converter, top level
//
// input channel: one signed q16.16 chebyshev coefficient per request, rising
// degree, valid/stall handshake. after n requests (n = term_count clamped to
// 1..MAX_TERMS) the block converts and sends n signed q48.16 power-series
// coefficients on the output channel, rising degree, last_term high on the last.
// cfg_we_i writes term_count and drops a partly loaded block.
// after reset the basis matrix of MAX_TERMS*MAX_TERMS entries (256 by default)
// is built into a ram, one entry a cycle; in_stall_o stays high meanwhile.
// loading accepts one request per cycle. conversion runs one shared multiplier
// and saturating accumulator through S_RD, S_MUL and S_ACC for each product,
// with (n-i+1)/2 products for p_i. in_stall_o is high during conversion. p_i
// is held in an output register; the next product runs while it waits, and a
// stalled receiver freezes the sequencer only when the following result is
// ready. the next block may load while the last result is still waiting.
module chebyshev_to_power_convert #(
  parameter int MAX_TERMS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cvp_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [cvp_pkg::COEF_W-1:0]   cheb_coefficient_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [cvp_pkg::POWER_W-1:0]  power_coefficient_o,
  output logic                                last_term_o
);

  localparam int NW    = $clog2(MAX_TERMS + 2);
  localparam int CAW   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int DEPTH = MAX_TERMS * MAX_TERMS;
  localparam int BAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [BAW-1:0] STEP_K = BAW'(2 * MAX_TERMS);
  localparam logic [BAW-1:0] STEP_D = BAW'(MAX_TERMS + 1);

  cvp_pkg::state_e state_q, state_d;

  logic [cvp_pkg::CFG_W-1:0] term_count_q, term_count_d;
  logic [NW-1:0] n_eff;
  logic [NW-1:0] load_cnt_q, load_cnt_d;
  logic [NW-1:0] i_q, i_d;
  logic [NW-1:0] k_q, k_d;
  logic [NW-1:0] k_next;
  logic [BAW-1:0] baddr_q, baddr_d;
  logic [BAW-1:0] diag_q, diag_d;
  logic signed [cvp_pkg::POWER_W-1:0] acc_q, acc_d;
  logic signed [cvp_pkg::PROD_W-1:0]  prod_q, prod_d;
  logic signed [cvp_pkg::POWER_W-1:0] sum;
  logic signed [cvp_pkg::POWER_W-1:0] power_q, power_d;
  logic last_q, last_d;
  logic out_valid_q, out_valid_d;
  logic out_free;
  logic in_acc;
  logic is_last;

  logic                                gen_we;
  logic [BAW-1:0]                      gen_addr;
  logic signed [cvp_pkg::BASIS_W-1:0]  gen_data;
  logic                                gen_done;
  logic [cvp_pkg::COEF_W-1:0]          coef_rd;
  logic [cvp_pkg::BASIS_W-1:0]         basis_rd;

  cvp_basis_gen #(
    .MAX_TERMS(MAX_TERMS)
  ) u_basis_gen (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .run_i (state_q == cvp_pkg::S_INIT),
    .we_o  (gen_we),
    .addr_o(gen_addr),
    .data_o(gen_data),
    .done_o(gen_done)
  );

  cvp_ram #(
    .WIDTH(cvp_pkg::BASIS_W),
    .DEPTH(DEPTH)
  ) u_basis_ram (
    .clk_i  (clk_i),
    .we_i   (gen_we),
    .waddr_i(gen_addr),
    .wdata_i(gen_data),
    .raddr_i(baddr_q),
    .rdata_o(basis_rd)
  );

  cvp_ram #(
    .WIDTH(cvp_pkg::COEF_W),
    .DEPTH(MAX_TERMS)
  ) u_coef_ram (
    .clk_i  (clk_i),
    .we_i   (in_acc),
    .waddr_i(load_cnt_q[CAW-1:0]),
    .wdata_i(cheb_coefficient_i),
    .raddr_i(k_q[CAW-1:0]),
    .rdata_o(coef_rd)
  );

  // clamp term_count to 1..MAX_TERMS
  always_comb begin
    if (term_count_q == '0) begin
      n_eff = NW'(1);
    end else if (int'(term_count_q) > MAX_TERMS) begin
      n_eff = NW'(MAX_TERMS);
    end else begin
      n_eff = NW'(term_count_q);
    end
  end

  assign in_stall_o = (state_q != cvp_pkg::S_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign k_next     = k_q + NW'(2);
  assign sum        = cvp_pkg::sat_add(acc_q, prod_q);
  assign is_last    = ((i_q + NW'(1)) == n_eff);

  always_comb begin
    state_d      = state_q;
    term_count_d = term_count_q;
    load_cnt_d   = load_cnt_q;
    i_d          = i_q;
    k_d          = k_q;
    baddr_d      = baddr_q;
    diag_d       = diag_q;
    acc_d        = acc_q;
    prod_d       = prod_q;
    power_d      = power_q;
    last_d       = last_q;
    out_valid_d  = out_valid_q && out_stall_i;

    case (state_q)
      cvp_pkg::S_INIT: begin
        if (gen_done) begin
          state_d = cvp_pkg::S_LOAD;
        end
      end
      cvp_pkg::S_LOAD: begin
        if (in_acc) begin
          if ((load_cnt_q + NW'(1)) >= n_eff) begin
            load_cnt_d = '0;
            i_d        = '0;
            k_d        = '0;
            baddr_d    = '0;
            diag_d     = '0;
            acc_d      = '0;
            state_d    = cvp_pkg::S_RD;
          end else begin
            load_cnt_d = load_cnt_q + NW'(1);
          end
        end
      end
      cvp_pkg::S_RD: begin
        state_d = cvp_pkg::S_MUL;
      end
      cvp_pkg::S_MUL: begin
        prod_d  = $signed(coef_rd) * $signed(basis_rd);
        state_d = cvp_pkg::S_ACC;
      end
      cvp_pkg::S_ACC: begin
        if (k_next < n_eff) begin
          acc_d   = sum;
          k_d     = k_next;
          baddr_d = baddr_q + STEP_K;
          state_d = cvp_pkg::S_RD;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          power_d     = sum;
          last_d      = is_last;
          if (is_last) begin
            state_d = cvp_pkg::S_LOAD;
          end else begin
            // next diagonal entry C(i+1, i+1)
            i_d     = i_q + NW'(1);
            k_d     = i_q + NW'(1);
            diag_d  = diag_q + STEP_D;
            baddr_d = diag_q + STEP_D;
            acc_d   = '0;
            state_d = cvp_pkg::S_RD;
          end
        end
      end
      default: begin
        state_d = cvp_pkg::S_INIT;
      end
    endcase

    if (cfg_we_i) begin
      term_count_d = cfg_wdata_i;
      load_cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cvp_pkg::S_INIT;
      term_count_q <= cvp_pkg::TERM_COUNT_RESET;
      load_cnt_q   <= '0;
      i_q          <= '0;
      k_q          <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      term_count_q <= term_count_d;
      load_cnt_q   <= load_cnt_d;
      i_q          <= i_d;
      k_q          <= k_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    baddr_q <= baddr_d;
    diag_q  <= diag_d;
    acc_q   <= acc_d;
    prod_q  <= prod_d;
    power_q <= power_d;
    last_q  <= last_d;
  end

  assign out_valid_o         = out_valid_q;
  assign power_coefficient_o = power_q;
  assign last_term_o         = last_q;

`ifndef ASSERT_OFF
  a_load_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cvp_pkg::S_LOAD) |-> (load_cnt_q < n_eff))
    else $error("load count beyond term count");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cvp_pkg::S_RD) |-> (k_q < n_eff))
    else $error("coefficient read beyond loaded block");

  a_basis_write_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_we |-> (state_q == cvp_pkg::S_INIT))
    else $error("basis ram written outside build pass");

  a_result_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == cvp_pkg::S_ACC) && !(k_next < n_eff) && out_free) |=> out_valid_o)
    else $error("finished sum not presented");
`endif

endmodule

// ----- bench/testbench.sv -----
// testbench for the chebyshev to power converter: scoreboard, request drivers and run sequence
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_TERMS    = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 3000;
  localparam int SETTLE       = 8;
  localparam int DRAIN        = 64;

  typedef struct {
    logic signed [cvp_pkg::POWER_W-1:0] power;
    logic                               last;
  } power_term_t;

  // expected power-series terms from the chebyshev coefficients taken in
  class power_board;
    logic [cvp_pkg::CFG_W-1:0] terms;
    int                        store[MAX_TERMS];
    int                        basis[MAX_TERMS][MAX_TERMS];  // [degree][power of x]
    int unsigned               loaded;
    power_term_t               power_due[$];
    int unsigned               coef_taken;
    int unsigned               power_seen;
    int unsigned               errors;
    int unsigned               out_index;

    function new();
      for (int k = 0; k < MAX_TERMS; k++) begin
        for (int j = 0; j < MAX_TERMS; j++) begin
          basis[k][j] = 0;
        end
      end
      basis[0][0] = 1;
      if (MAX_TERMS > 1) basis[1][1] = 1;
      // T_k = 2x T_(k-1) - T_(k-2)
      for (int k = 2; k < MAX_TERMS; k++) begin
        for (int j = 0; j <= k; j++) begin
          basis[k][j] = ((j >= 1) ? 2 * basis[k-1][j-1] : 0) - basis[k-2][j];
        end
      end
      terms      = cvp_pkg::TERM_COUNT_RESET;
      loaded     = 0;
      coef_taken = 0;
      power_seen = 0;
      errors     = 0;
      out_index  = 0;
    endfunction

    function void set_terms(logic [cvp_pkg::CFG_W-1:0] v);
      terms  = v;
      loaded = 0;
    endfunction

    function int unsigned terms_in_use();
      if (terms == 0) return 1;
      if (terms > MAX_TERMS) return MAX_TERMS;
      return terms;
    endfunction

    function int pending();
      return power_due.size();
    endfunction

    function logic signed [cvp_pkg::POWER_W-1:0] sat_sum(
      logic signed [cvp_pkg::POWER_W-1:0] a,
      logic signed [cvp_pkg::POWER_W-1:0] b
    );
      logic [cvp_pkg::POWER_W:0] s;
      s = {a[cvp_pkg::POWER_W-1], a} + {b[cvp_pkg::POWER_W-1], b};
      if (s[cvp_pkg::POWER_W] != s[cvp_pkg::POWER_W-1]) begin
        return s[cvp_pkg::POWER_W] ? {1'b1, {(cvp_pkg::POWER_W-1){1'b0}}}
                                   : {1'b0, {(cvp_pkg::POWER_W-1){1'b1}}};
      end
      return s[cvp_pkg::POWER_W-1:0];
    endfunction

    function void take_coefficient(logic [cvp_pkg::COEF_W-1:0] c);
      int unsigned n;
      power_term_t t;
      logic signed [cvp_pkg::POWER_W-1:0] acc;
      n = terms_in_use();
      coef_taken++;
      if (loaded >= n) loaded = 0;
      store[loaded] = $signed(c);
      loaded++;
      if (loaded < n) return;
      loaded = 0;
      for (int i = 0; i < n; i++) begin
        acc = '0;
        for (int k = i; k < n; k += 2) begin
          acc = sat_sum(acc, longint'(basis[k][i]) * longint'(store[k]));
        end
        t.power = acc;
        t.last  = (i + 1 == n);
        power_due.push_back(t);
      end
    endfunction

    function void check_power(logic signed [cvp_pkg::POWER_W-1:0] p, logic l);
      power_term_t t;
      power_seen++;
      if (power_due.size() == 0) begin
        $display("%0t: power coefficient with none expected: got %0d last %b",
                 $time, p, l);
        errors++;
        return;
      end
      t = power_due.pop_front();
      if (p !== t.power) begin
        $display("%0t: power_coefficient p_%0d expected %0d got %0d",
                 $time, out_index, t.power, p);
        errors++;
      end
      if (l !== t.last) begin
        $display("%0t: last_term p_%0d expected %b got %b", $time, out_index, t.last, l);
        errors++;
      end
      out_index = t.last ? 0 : out_index + 1;
    endfunction
  endclass

  logic                                clk_i;
  logic                                rst_n;
  logic                                cfg_we;
  logic [cvp_pkg::CFG_W-1:0]           cfg_wdata;
  logic                                coef_valid;
  logic                                coef_stall;
  logic signed [cvp_pkg::COEF_W-1:0]   cheb_coef;
  logic                                power_valid;
  logic                                power_stall;
  logic signed [cvp_pkg::POWER_W-1:0]  power_coef;
  logic                                last_term;

  logic                       steady;
  logic                       hold_off_req;
  int unsigned                quiet_cycles;
  int unsigned                terms_writes;
  int unsigned                cut_blocks;

  power_board board = new();

  chebyshev_to_power_convert #(
    .MAX_TERMS(MAX_TERMS)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (coef_valid),
    .in_stall_o         (coef_stall),
    .cheb_coefficient_i (cheb_coef),
    .out_valid_o        (power_valid),
    .out_stall_i        (power_stall),
    .power_coefficient_o(power_coef),
    .last_term_o        (last_term)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    bit held;
    held        = 1'b0;
    power_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !held) begin
        power_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        held = 1'b1;
      end else begin
        power_stall = !steady && ($urandom_range(0, 99) < 15);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_n && power_valid && !power_stall) begin
      board.check_power(power_coef, last_term);
    end
  end

  always @(posedge clk_i) begin
    if ((coef_valid && !coef_stall) || (power_valid && !power_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_coef(input logic [cvp_pkg::COEF_W-1:0] c);
    @(negedge clk_i);
    if (!steady && $urandom_range(0, 99) < 15) begin
      coef_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    coef_valid = 1'b1;
    cheb_coef  = c;
    @(posedge clk_i);
    while (coef_stall) @(posedge clk_i);
    board.take_coefficient(c);
  endtask

  // all expected terms out, then a SETTLE wait for the loader to go idle
  task automatic wait_quiet();
    @(negedge clk_i);
    coef_valid = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_terms(input logic [cvp_pkg::CFG_W-1:0] v);
    wait_quiet();
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk_i);
    cfg_we = 1'b0;
    board.set_terms(v);
    terms_writes++;
  endtask

  function automatic logic [cvp_pkg::COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  localparam logic [cvp_pkg::COEF_W-1:0] EDGE_COEFS [16] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA
  };

  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned blocks;
    logic [cvp_pkg::CFG_W-1:0] v;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    coef_valid   = 1'b0;
    cheb_coef    = '0;
    steady       = 1'b0;
    hold_off_req = 1'b0;
    terms_writes = 0;
    cut_blocks   = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    // full block at the reset term count, extreme coefficients
    for (int i = 0; i < 16; i++) send_coef(EDGE_COEFS[i]);
    // single term passes straight through
    write_terms(5'd1);
    send_coef(32'h7FFF_FFFF);
    send_coef(32'h8000_0000);
    // zero term count acts as one
    write_terms(5'd0);
    send_coef(32'hFFFF_FFFF);
    // a write drops a partly loaded block
    write_terms(5'd3);
    send_coef(32'h1234_5678);
    send_coef(32'h8765_4321);
    cut_blocks++;
    write_terms(5'd2);
    send_coef(32'h8000_0000);
    send_coef(32'h7FFF_FFFF);

    phase = 0;
    while (board.coef_taken < 260) begin
      case (phase)
        0:       v = 5'd31;
        1:       v = 5'd4;
        2:       v = 5'd0;
        3:       v = 5'd16;
        4:       v = 5'd1;
        default: begin
          case ($urandom_range(0, 9))
            0:       v = 5'd0;
            1:       v = 5'd1;
            2:       v = 5'd16;
            3:       v = cvp_pkg::CFG_W'($urandom_range(17, 31));
            default: v = cvp_pkg::CFG_W'($urandom_range(2, 15));
          endcase
        end
      endcase
      write_terms(v);
      n = board.terms_in_use();
      blocks = (n >= 8) ? $urandom_range(1, 3) : $urandom_range(2, 8);
      if (phase == 1) begin
        // receiver holds off while requests keep coming, so the block backs up
        blocks       = 10;
        hold_off_req = 1'b1;
      end
      steady = (phase == 3);
      for (int b = 0; b < blocks; b++) begin
        for (int i = 0; i < n; i++) send_coef(rand_coef());
      end
      if (n > 1 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, n - 1)) send_coef(rand_coef());
        cut_blocks++;
      end
      steady = 1'b0;
      phase++;
    end

    @(negedge clk_i);
    coef_valid = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("run: %0d chebyshev coefficients in, %0d power coefficients checked",
             board.coef_taken, board.power_seen);
    $display("run: %0d term_count writes incl. 0, 1, 16, 31; %0d partial blocks dropped",
             terms_writes, cut_blocks);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/cvp_pkg.sv
rtl/core/cvp_ram.sv
rtl/core/cvp_basis_gen.sv
rtl/core/chebyshev_to_power_convert.sv
bench/testbench.sv
